### design/alu16f_pkg.sv
// ----------------------------------------------------------------------------
// alu16f_pkg: shared definitions of the 16-bit alu with status flags
// operation codes, flag positions and the request/response structs between
// the sequencer and the shared arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package alu16f_pkg;

    // data path width and step count of the iterative operations
    localparam int DATA_W = 16;
    localparam int STEPS  = DATA_W;
    localparam int CNT_W  = $clog2(STEPS);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    localparam logic [DATA_W-1:0] SIGN_MASK = 16'h8000;
    localparam logic [DATA_W-1:0] ALL_ONES  = 16'hFFFF;

    typedef logic [3:0]        t_op;
    typedef logic [DATA_W-1:0] t_word;

    // operation codes
    localparam t_op OP_ADD = 4'd0;
    localparam t_op OP_SUB = 4'd1;
    localparam t_op OP_MUL = 4'd2;
    localparam t_op OP_DIV = 4'd3;
    localparam t_op OP_INC = 4'd4;
    localparam t_op OP_DEC = 4'd5;
    localparam t_op OP_AND = 4'd6;
    localparam t_op OP_OR  = 4'd7;
    localparam t_op OP_XOR = 4'd8;
    localparam t_op OP_NOT = 4'd9;

    // flag register bit positions
    localparam int FLAG_Z = 0;
    localparam int FLAG_N = 1;
    localparam int FLAG_C = 2;
    localparam int FLAG_V = 3;

    // start of one item in the shared unit
    typedef struct packed {
        logic  start;
        t_op   op;
        t_word a;
        t_word b;
    } t_unit_req;

    // finished item from the shared unit
    typedef struct packed {
        logic  done;
        t_word value;
        logic  carry;
        logic  ovf;
    } t_unit_rsp;

endpackage

`default_nettype wire

### design/alu16f_unit.sv
// ----------------------------------------------------------------------------
// alu16f_unit: shared arithmetic unit
// one 17-bit adder used for add, sub, inc, dec in a single step, and for
// sixteen shift-add steps of mul or sixteen restoring steps of div
// ----------------------------------------------------------------------------
`default_nettype none

module alu16f_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  alu16f_pkg::t_unit_req i_req,
    output alu16f_pkg::t_unit_rsp o_rsp
);
    import alu16f_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    t_op              r_op;
    t_word            r_acc;
    t_word            r_x;
    t_word            r_y;
    logic             r_done;
    t_word            r_value;
    logic             r_carry;
    logic             r_ovf;

    logic              is_mul;
    logic              is_div;
    logic              last;
    logic [DATA_W:0]   add_x;
    logic [DATA_W:0]   add_y;
    logic              add_cin;
    logic [DATA_W+1:0] sum;
    logic              div_ge;
    t_word             n_acc;
    t_word             n_x;
    t_word             n_value;
    logic              n_carry;
    logic              n_ovf;

    assign is_mul = (r_op == OP_MUL);
    assign is_div = (r_op == OP_DIV);
    assign last   = !(is_mul || is_div) || (r_cnt == CNT_LAST);

    // operand selection for the shared adder
    always_comb begin
        add_x   = {1'b0, r_x};
        add_y   = {1'b0, r_y};
        add_cin = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                add_y = {1'b0, r_y};
            end
            OP_SUB: begin
                add_y   = ~{1'b0, r_y};
                add_cin = 1'b1;
            end
            OP_INC: begin
                add_y   = '0;
                add_cin = 1'b1;
            end
            OP_DEC: begin
                add_y = {1'b0, ALL_ONES};
            end
            OP_MUL: begin
                add_x = {1'b0, r_acc};
                add_y = r_y[0] ? {1'b0, r_x} : '0;
            end
            OP_DIV: begin
                add_x   = {r_acc, r_x[DATA_W-1]};
                add_y   = ~{1'b0, r_y};
                add_cin = 1'b1;
            end
            default: begin
                add_y = '0;
            end
        endcase
    end

    assign sum    = {1'b0, add_x} + {1'b0, add_y} + {{(DATA_W+1){1'b0}}, add_cin};
    assign div_ge = sum[DATA_W+1];

    // next partial product or partial remainder and quotient
    always_comb begin
        n_acc = r_acc;
        n_x   = r_x;
        if (is_mul) begin
            n_acc = sum[DATA_W-1:0];
            n_x   = {r_x[DATA_W-2:0], 1'b0};
        end else if (is_div) begin
            n_acc = div_ge ? sum[DATA_W-1:0] : add_x[DATA_W-1:0];
            n_x   = {r_x[DATA_W-2:0], div_ge};
        end
    end

    // result and carry/overflow of the finishing step
    always_comb begin
        n_value = '0;
        n_carry = 1'b0;
        n_ovf   = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                n_value = sum[DATA_W-1:0];
                n_carry = sum[DATA_W];
                n_ovf   = |(~(r_x ^ r_y) & (r_x ^ sum[DATA_W-1:0]) & SIGN_MASK);
            end
            OP_SUB: begin
                n_value = sum[DATA_W-1:0];
                n_carry = ~sum[DATA_W+1];
                n_ovf   = |((r_x ^ r_y) & (r_x ^ sum[DATA_W-1:0]) & SIGN_MASK);
            end
            OP_INC, OP_DEC: n_value = sum[DATA_W-1:0];
            OP_MUL:         n_value = n_acc;
            OP_DIV:         n_value = n_x;
            OP_AND:         n_value = r_x & r_y;
            OP_OR:          n_value = r_x | r_y;
            OP_XOR:         n_value = r_x ^ r_y;
            OP_NOT:         n_value = ~r_x;
            default:        n_value = '0;
        endcase
    end

    // control: busy flag and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and result registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_x   <= i_req.a;
            r_y   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_x   <= n_x;
            if (is_mul) begin
                r_y <= {1'b0, r_y[DATA_W-1:1]};
            end
            if (last) begin
                r_value <= n_value;
                r_carry <= n_carry;
                r_ovf   <= n_ovf;
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;
    assign o_rsp.carry = r_carry;
    assign o_rsp.ovf   = r_ovf;

endmodule

`default_nettype wire

### design/alu16_with_flags.sv
// ----------------------------------------------------------------------------
// alu16_with_flags: 16-bit alu with zero, negative, carry and overflow flags
// sequencer around one shared adder unit, with sticky halt on divide by zero
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  input   | in        | i_valid / o_ready  | operation, operand a, operand b
//  result  | out       | o_valid / i_ready  | value, four flags, halt, fault
//
//  add, sub, inc, dec and the logic operations pass the shared unit without
//  iterating; mul and div run one shift-add or restoring step per cycle
//  through the shared adder. a new item is taken once the result has left,
//  so items never overlap. o_ready is low from accept until the result is
//  taken; a stalled result holds in the output register. reset clears flags,
//  halt and fault code; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module alu16_with_flags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  alu16f_pkg::t_op     i_operation,
    input  alu16f_pkg::t_word   i_operand_a,
    input  alu16f_pkg::t_word   i_operand_b,
    output logic                o_valid,
    input  logic                i_ready,
    output alu16f_pkg::t_word   o_value,
    output logic                o_zero_flag,
    output logic                o_negative_flag,
    output logic                o_carry_flag,
    output logic                o_overflow_flag,
    output logic                o_halt,
    output logic                o_fault_code
);
    import alu16f_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_op        r_op;
    logic       r_b_zero;
    logic [3:0] r_flags;
    logic [3:0] n_flags;
    logic       r_halt;
    logic       r_fault;
    logic       n_fault_hit;
    t_word      r_value;
    t_word      n_value;

    t_unit_req  req;
    t_unit_rsp  rsp;
    logic       accept;

    assign accept = i_valid && o_ready;

    // shared arithmetic unit
    assign req.start = accept;
    assign req.op    = i_operation;
    assign req.a     = i_operand_a;
    assign req.b     = i_operand_b;

    alu16f_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept)   n_state = ST_BUSY;
            ST_BUSY: if (rsp.done) n_state = ST_OUT;
            ST_OUT:  if (i_ready)  n_state = ST_IDLE;
            default:               n_state = ST_IDLE;
        endcase
    end

    // flag update and special cases
    always_comb begin
        n_flags     = r_flags;
        n_value     = rsp.value;
        n_fault_hit = 1'b0;
        unique case (r_op)
            OP_ADD, OP_SUB: begin
                n_flags[FLAG_Z] = (rsp.value == '0);
                n_flags[FLAG_N] = rsp.value[DATA_W-1];
                n_flags[FLAG_C] = rsp.carry;
                n_flags[FLAG_V] = rsp.ovf;
            end
            OP_INC, OP_DEC: begin
                n_flags[FLAG_Z] = (rsp.value == '0);
                n_flags[FLAG_N] = rsp.value[DATA_W-1];
            end
            OP_DIV: begin
                if (r_b_zero) begin
                    n_value     = '0;
                    n_fault_hit = 1'b1;
                end else begin
                    n_flags[FLAG_Z] = (rsp.value == '0);
                    n_flags[FLAG_N] = rsp.value[DATA_W-1];
                    n_flags[FLAG_C] = 1'b0;
                    n_flags[FLAG_V] = 1'b0;
                end
            end
            OP_MUL, OP_AND, OP_OR, OP_XOR, OP_NOT: begin
                n_flags[FLAG_Z] = (rsp.value == '0);
                n_flags[FLAG_N] = rsp.value[DATA_W-1];
                n_flags[FLAG_C] = 1'b0;
                n_flags[FLAG_V] = 1'b0;
            end
            default: begin
                n_value = '0;
            end
        endcase
    end

    // control state, flags and sticky halt
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_flags <= '0;
            r_halt  <= 1'b0;
            r_fault <= 1'b0;
        end else begin
            r_state <= n_state;
            if (rsp.done && r_state == ST_BUSY) begin
                r_flags <= n_flags;
                if (n_fault_hit) begin
                    r_halt  <= 1'b1;
                    r_fault <= 1'b1;
                end
            end
        end
    end

    // item capture and result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_operation;
            r_b_zero <= (i_operand_b == '0);
        end
        if (rsp.done && r_state == ST_BUSY) begin
            r_value <= n_value;
        end
    end

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = (r_state == ST_OUT);
    assign o_value         = r_value;
    assign o_zero_flag     = r_flags[FLAG_Z];
    assign o_negative_flag = r_flags[FLAG_N];
    assign o_carry_flag    = r_flags[FLAG_C];
    assign o_overflow_flag = r_flags[FLAG_V];
    assign o_halt          = r_halt;
    assign o_fault_code    = r_fault;

endmodule

`default_nettype wire

### design/alu16f_chk.sv
// ----------------------------------------------------------------------------
// alu16f_chk: port checker of the 16-bit alu with status flags
// watches handshakes, sticky halt and flag consistency at the top level ports
// ----------------------------------------------------------------------------
`default_nettype none

module alu16f_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_ready,
    input  alu16f_pkg::t_op   i_operation,
    input  alu16f_pkg::t_word i_operand_a,
    input  alu16f_pkg::t_word i_operand_b,
    input  logic              o_valid,
    input  logic              i_ready,
    input  alu16f_pkg::t_word o_value,
    input  logic              o_zero_flag,
    input  logic              o_negative_flag,
    input  logic              o_carry_flag,
    input  logic              o_overflow_flag,
    input  logic              o_halt,
    input  logic              o_fault_code
);
    import alu16f_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value))
        else $error("result changed while stalled");

    // one item at a time: no new item while a result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input ready while result pending");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_halt |=> o_halt)
        else $error("halt dropped without reset");

    // halt and fault code are set by the same event
    a_halt_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_halt == o_fault_code)
        else $error("halt and fault code disagree");

    // a non-zero result always carries its own zero and sign flags
    a_zn_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_value != '0) |->
            !o_zero_flag && (o_negative_flag == o_value[DATA_W-1]))
        else $error("zero or negative flag does not match result");

endmodule

bind alu16_with_flags alu16f_chk u_alu16f_chk (.*);

`default_nettype wire
